### rtl/tcas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_pkg
// Shared types, codes and helpers of the two-class aging scheduler.
// ----------------------------------------------------------------------------
package tcas_pkg;

    localparam int TASK_COUNT = 32;
    localparam int IDX_W      = $clog2(TASK_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

    // command codes
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_SCHED  = 3'd1;
    localparam logic [2:0] CMD_RESUME = 3'd2;
    localparam logic [2:0] CMD_YIELD  = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    // task status codes
    localparam logic [1:0] ST_WAITING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_STOPPED = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ALARM   = 2'd0;
    localparam logic [1:0] KIND_STOPPED = 2'd1;
    localparam logic [1:0] KIND_GRANT   = 2'd2;

    localparam logic [15:0] QUANTUM_RST = 16'd50;

    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [1:0]  entry_status;
        logic        entry_superuser;
        logic [15:0] entry_counter;
        logic [31:0] entry_alarm;
        logic [31:0] tick;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] task_index;
        logic       switched;
        logic       last;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic        superuser;
        logic [15:0] counter;
        logic [31:0] alarm;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // saturating age step of a wait counter
    function automatic logic [15:0] age(input logic [15:0] cnt);
        age = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
    endfunction

endpackage
`default_nettype wire

### rtl/tcas_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcas channel interfaces
// Valid/ready channels for command requests and scheduler results.
// ----------------------------------------------------------------------------
interface tcas_req_if;
    logic          valid;
    logic          ready;
    tcas_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tcas_rsp_if;
    logic          valid;
    logic          ready;
    tcas_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/tcas_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module tcas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            // forward a write to the same entry
            if (i_we && (i_waddr == i_raddr)) begin
                o_rdata <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_raddr];
            end
        end
    end
endmodule
`default_nettype wire

### rtl/two_class_aging_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_aging_scheduler
// Task table in one RAM, walked by a read-modify-write sequencer for alarm
// expiry and two-class aging selection.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     carries
//  i_req     in   valid/ready   command, entry fields, tick
//  o_rsp     out  valid/ready   kind, task_index, switched, last
//  i_cfg_*   in   write enable  quantum
//
// Write and unknown commands finish in the idle state; schedule and resume add
// one entry step (S_ENT). Yield and stop each walk the table in an alarm pass,
// then in a selection pass, one RAM entry per cycle over entries 1 to
// TASK_COUNT - 1; the single RAM port pair sets this pace. Output stalls hold
// the pass only when a result is due.
// Reset is synchronous: entries read as zero until written (one valid flop
// per entry), the current task is the idle entry and quantum is 50.
// ----------------------------------------------------------------------------
module two_class_aging_scheduler (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tcas_req_if.sink     i_req,
    tcas_rsp_if.source   o_rsp,
    input  wire          i_cfg_we,
    input  wire [15:0]   i_cfg_data
);
    import tcas_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ENT   = 7'b0000010,  // schedule / resume / stop on one entry
        S_PRV   = 7'b0000100,  // requeue the running current task
        S_ALM   = 7'b0001000,  // alarm pass and superuser census
        S_LD    = 7'b0010000,  // load idle entry as first leader
        S_SEL   = 7'b0100000,  // selection pass with aging
        S_GRANT = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_cmd, n_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_tick, n_tick;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_lead_idx, n_lead_idx;
    t_entry           r_lead, n_lead;
    logic             r_any_super, n_any_super;
    logic             r_o_valid, n_o_valid;
    t_rsp             r_o, n_o;
    logic [15:0]      r_quantum;
    logic [TASK_COUNT-1:0] r_init;
    logic             r_rd_init, n_rd_init;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_entry           ram_wdata;
    logic [ENTRY_W-1:0] ram_q;
    t_entry           rd;
    logic             out_free, req_fire, in_table, expired, eligible;
    t_req             req;

    tcas_ram #(.WIDTH(ENTRY_W), .DEPTH(TASK_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign req       = i_req.payload;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire  = i_req.valid && i_req.ready;
    assign in_table  = (32'(req.entry_index) < TASK_COUNT);
    assign out_free  = !r_o_valid || o_rsp.ready;
    // an entry never written reads as its reset value
    assign rd        = r_rd_init ? t_entry'(ram_q) : '0;
    assign expired   = rd.valid && (rd.alarm != 32'd0) && (rd.alarm < r_tick);
    assign eligible  = (rd.status == ST_READY) && (rd.superuser == r_any_super);

    assign o_rsp.valid   = r_o_valid;
    assign o_rsp.payload = r_o;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_tick      = r_tick;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_i         = r_i;
        n_lead_idx  = r_lead_idx;
        n_lead      = r_lead;
        n_any_super = r_any_super;
        n_o_valid   = r_o_valid && !o_rsp.ready;
        n_o         = r_o;
        ram_we      = 1'b0;
        ram_waddr   = r_i;
        ram_wdata   = rd;
        ram_re      = 1'b0;
        ram_raddr   = IDX_W'(r_i + 1'b1);

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_cmd  = req.command;
                    n_idx  = IDX_W'(req.entry_index);
                    n_tick = req.tick;
                    n_prev = r_cur;
                    case (req.command)
                        CMD_WRITE: begin
                            if (in_table) begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(req.entry_index);
                                ram_wdata = '{valid: req.entry_valid,
                                              status: req.entry_status,
                                              superuser: req.entry_superuser,
                                              counter: req.entry_counter,
                                              alarm: req.entry_alarm};
                            end
                        end
                        CMD_SCHED, CMD_RESUME: begin
                            if (in_table) begin
                                ram_re    = 1'b1;
                                ram_raddr = IDX_W'(req.entry_index);
                                n_state   = S_ENT;
                            end
                        end
                        CMD_STOP: begin
                            ram_re    = 1'b1;
                            ram_raddr = r_cur;
                            n_idx     = r_cur;
                            n_state   = S_ENT;
                        end
                        CMD_YIELD: begin
                            ram_re    = 1'b1;
                            ram_raddr = r_cur;
                            n_state   = S_PRV;
                        end
                        default: ;
                    endcase
                end
            end

            S_ENT: begin
                ram_waddr = r_idx;
                case (r_cmd)
                    CMD_SCHED: begin
                        ram_we            = 1'b1;
                        ram_wdata.status  = ST_READY;
                        ram_wdata.counter = 16'd0;
                        n_state           = S_IDLE;
                    end
                    CMD_RESUME: begin
                        ram_we            = (rd.status == ST_STOPPED);
                        ram_wdata.status  = ST_READY;
                        ram_wdata.counter = 16'd0;
                        n_state           = S_IDLE;
                    end
                    CMD_STOP: begin
                        if (out_free) begin
                            ram_we           = 1'b1;
                            ram_wdata.status = ST_STOPPED;
                            n_o_valid        = 1'b1;
                            n_o              = '{kind: KIND_STOPPED,
                                                 task_index: 5'(r_idx),
                                                 switched: 1'b0, last: 1'b0};
                            // status now stopped: no requeue step needed
                            ram_re           = 1'b1;
                            ram_raddr        = IDX_W'(1);
                            n_i              = IDX_W'(1);
                            n_any_super      = 1'b0;
                            n_state          = S_ALM;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_PRV: begin
                ram_waddr         = r_prev;
                ram_we            = (rd.status == ST_RUNNING);
                ram_wdata.status  = ST_READY;
                ram_wdata.counter = 16'd0;
                ram_re            = 1'b1;
                ram_raddr         = IDX_W'(1);
                n_i               = IDX_W'(1);
                n_any_super       = 1'b0;
                n_state           = S_ALM;
            end

            S_ALM: begin
                // hold the pass while an expired alarm cannot be reported
                if (!expired || out_free) begin
                    if (expired) begin
                        ram_we          = 1'b1;
                        ram_wdata.alarm = 32'd0;
                        n_o_valid       = 1'b1;
                        n_o             = '{kind: KIND_ALARM,
                                            task_index: 5'(r_i),
                                            switched: 1'b0, last: 1'b0};
                    end
                    if ((rd.status == ST_READY) && rd.superuser) begin
                        n_any_super = 1'b1;
                    end
                    ram_re = 1'b1;
                    if (r_i == LAST_IDX) begin
                        ram_raddr = '0;
                        n_state   = S_LD;
                    end else begin
                        n_i = IDX_W'(r_i + 1'b1);
                    end
                end
            end

            S_LD: begin
                n_lead     = rd;
                n_lead_idx = '0;
                ram_re     = 1'b1;
                ram_raddr  = IDX_W'(1);
                n_i        = IDX_W'(1);
                n_state    = S_SEL;
            end

            S_SEL: begin
                if (eligible) begin
                    ram_we = 1'b1;
                    if (rd.counter > r_lead.counter) begin
                        // new leader; age the old one
                        ram_waddr         = r_lead_idx;
                        ram_wdata         = r_lead;
                        ram_wdata.counter = age(r_lead.counter);
                        n_lead            = rd;
                        n_lead_idx        = r_i;
                    end else begin
                        ram_wdata.counter = age(rd.counter);
                    end
                end
                if (r_i == LAST_IDX) begin
                    n_state = S_GRANT;
                end else begin
                    ram_re = 1'b1;
                    n_i    = IDX_W'(r_i + 1'b1);
                end
            end

            S_GRANT: begin
                if (out_free) begin
                    ram_we            = 1'b1;
                    ram_waddr         = r_lead_idx;
                    ram_wdata         = r_lead;
                    ram_wdata.status  = ST_RUNNING;
                    ram_wdata.counter = r_quantum;
                    n_o_valid         = 1'b1;
                    n_o               = '{kind: KIND_GRANT,
                                          task_index: 5'(r_lead_idx),
                                          switched: (r_lead_idx != r_prev),
                                          last: 1'b1};
                    n_cur             = r_lead_idx;
                    n_state           = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        n_rd_init = r_rd_init;
        if (ram_re) begin
            n_rd_init = r_init[ram_raddr] || (ram_we && (ram_waddr == ram_raddr));
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_o_valid <= 1'b0;
            r_quantum <= QUANTUM_RST;
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_o_valid <= n_o_valid;
            r_rd_init <= n_rd_init;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
            if (ram_we) begin
                r_init[ram_waddr] <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_tick      <= n_tick;
        r_prev      <= n_prev;
        r_i         <= n_i;
        r_lead_idx  <= n_lead_idx;
        r_lead      <= n_lead;
        r_any_super <= n_any_super;
        r_o         <= n_o;
    end

    a_grant_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o.kind == KIND_GRANT)) |-> r_o.last)
        else $error("grant result without last");

    a_grant_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_GRANT) && out_free) |=> (r_state == S_IDLE))
        else $error("grant did not return to idle");

    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur) < TASK_COUNT))
        else $error("current task outside table");

    a_no_emit_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_rsp.ready) |=> ($stable(r_o) && r_o_valid))
        else $error("pending result overwritten");

    a_pass_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ALM) || (r_state == S_SEL)) |-> (r_i != '0))
        else $error("pass visits idle entry");
endmodule
`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// Two-class aging scheduler testbench
// Drives task-table commands through the request channel. A model of the
// table, kept in the bench, works out the alarm, stop and grant results that
// each command should give, and each result that comes back is checked
// against the oldest one still outstanding. The run covers directed corner
// cases, random command streams under several idling patterns, quantum
// settings and long back-pressure on the result channel.
// ----------------------------------------------------------------------------
module tb;
    import tcas_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 2 * TASK_COUNT + 16;

    // idling patterns
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    tcas_req_if req_ch ();
    tcas_rsp_if rsp_ch ();

    two_class_aging_scheduler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Copy of the task table as the scheduler should hold it
    logic        tbl_valid  [TASK_COUNT];
    logic [1:0]  tbl_status [TASK_COUNT];
    logic        tbl_super  [TASK_COUNT];
    logic [15:0] tbl_count  [TASK_COUNT];
    logic [31:0] tbl_alarm  [TASK_COUNT];
    logic [4:0]  cur_task;
    logic [15:0] quantum_val;

    t_rsp pending_results[$];

    int idle_mode;
    int hold_req;
    int err_count;
    int req_count;
    int rsp_count;
    int grant_count;
    int alarm_count;
    int stop_count;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    function automatic void queue_result(logic [1:0] k, logic [4:0] idx, logic sw,
                                         logic lst);
        t_rsp r;
        r.kind       = k;
        r.task_index = idx;
        r.switched   = sw;
        r.last       = lst;
        pending_results.push_back(r);
    endfunction

    function automatic logic [15:0] aged(logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    // Requeue the running task, report expired alarms, then pick the leader
    function automatic void yield_predict(logic [31:0] tk);
        logic [4:0] prev;
        logic [4:0] lead;
        logic       any_super;
        prev      = cur_task;
        lead      = '0;
        any_super = 1'b0;
        if (tbl_status[prev] == ST_RUNNING) begin
            tbl_status[prev] = ST_READY;
            tbl_count[prev]  = '0;
        end
        for (int i = 1; i < TASK_COUNT; i++) begin
            if (tbl_valid[i] && tbl_alarm[i] != 0 && tbl_alarm[i] < tk) begin
                tbl_alarm[i] = '0;
                queue_result(KIND_ALARM, 5'(i), 1'b0, 1'b0);
            end
        end
        for (int i = 1; i < TASK_COUNT; i++)
            if (tbl_status[i] == ST_READY && tbl_super[i])
                any_super = 1'b1;
        // only the class that wins this round is aged
        for (int i = 1; i < TASK_COUNT; i++) begin
            if (tbl_status[i] != ST_READY || tbl_super[i] != any_super)
                continue;
            if (tbl_count[i] > tbl_count[lead]) begin
                tbl_count[lead] = aged(tbl_count[lead]);
                lead = 5'(i);
            end else begin
                tbl_count[i] = aged(tbl_count[i]);
            end
        end
        tbl_status[lead] = ST_RUNNING;
        tbl_count[lead]  = quantum_val;
        cur_task         = lead;
        queue_result(KIND_GRANT, lead, lead != prev, 1'b1);
    endfunction

    function automatic void sched_predict(t_req r);
        case (r.command)
            CMD_WRITE: begin
                tbl_valid[r.entry_index]  = r.entry_valid;
                tbl_status[r.entry_index] = r.entry_status;
                tbl_super[r.entry_index]  = r.entry_superuser;
                tbl_count[r.entry_index]  = r.entry_counter;
                tbl_alarm[r.entry_index]  = r.entry_alarm;
            end
            CMD_SCHED: begin
                tbl_status[r.entry_index] = ST_READY;
                tbl_count[r.entry_index]  = '0;
            end
            CMD_RESUME: begin
                if (tbl_status[r.entry_index] == ST_STOPPED) begin
                    tbl_status[r.entry_index] = ST_READY;
                    tbl_count[r.entry_index]  = '0;
                end
            end
            CMD_YIELD: yield_predict(r.tick);
            CMD_STOP: begin
                tbl_status[cur_task] = ST_STOPPED;
                queue_result(KIND_STOPPED, cur_task, 1'b0, 1'b0);
                yield_predict(r.tick);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: hold valid until the scheduler takes the request
    // ------------------------------------------------------------------
    task automatic send_request(t_req r);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(negedge i_clk); while (!req_ch.ready);
        @(posedge i_clk);
        sched_predict(r);
        req_count++;
        // sender gaps only in the idling phases that call for them
        if ((idle_mode == IDLE_SEND && $urandom_range(99) < 57) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 8)) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    function automatic t_req make_req(logic [2:0] cmd, logic [4:0] idx);
        t_req r;
        r             = '0;
        r.command     = cmd;
        r.entry_index = idx;
        r.tick        = $urandom;
        return r;
    endfunction

    task automatic write_entry(logic [4:0] idx, logic v, logic [1:0] st, logic su,
                               logic [15:0] cnt, logic [31:0] alm);
        t_req r;
        r                 = make_req(CMD_WRITE, idx);
        r.entry_valid     = v;
        r.entry_status    = st;
        r.entry_superuser = su;
        r.entry_counter   = cnt;
        r.entry_alarm     = alm;
        send_request(r);
    endtask

    task automatic yield_at(logic [2:0] cmd, logic [31:0] tk);
        t_req r;
        r      = make_req(cmd, 5'($urandom));
        r.tick = tk;
        send_request(r);
    endtask

    // Wait for every outstanding result, then let a result-less command finish
    task automatic drain;
        req_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_quantum(logic [15:0] q);
        drain();
        cfg_we      <= 1'b1;
        cfg_data    <= q;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        quantum_val  = q;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
            rsp_ch.ready <= $urandom_range(99) >=
                            ((idle_mode == IDLE_RECV) ? 57 : 8);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Sample mid-cycle; the transfer completes at the next rising edge
    always @(negedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            rsp_count++;
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind || got.task_index != want.task_index ||
                    got.switched != want.switched || got.last != want.last) begin
                    err_count++;
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, want, got);
                end
                if (want.kind == KIND_GRANT)   grant_count++;
                if (want.kind == KIND_ALARM)   alarm_count++;
                if (want.kind == KIND_STOPPED) stop_count++;
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(negedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed;
        t_req r;
        idle_mode = IDLE_NONE;
        // empty table: idle entry keeps the processor, then stop it
        yield_at(CMD_YIELD, 32'hFFFF_FFFF);
        yield_at(CMD_STOP, 32'd0);
        // user tasks with extreme fields, one saturated counter
        write_entry(5'd1, 1'b1, ST_READY, 1'b0, 16'hFFFF, 32'd0);
        write_entry(5'd31, 1'b1, ST_READY, 1'b0, 16'hFFFE, 32'hFFFF_FFFF);
        write_entry(5'd2, 1'b1, ST_WAITING, 1'b0, 16'd0, 32'd100);
        write_entry(5'd3, 1'b0, ST_WAITING, 1'b0, 16'd7, 32'd5);  // invalid, alarm ignored
        write_entry(5'd4, 1'b1, ST_WAITING, 1'b0, 16'd0, 32'd200); // alarm equal to tick
        yield_at(CMD_YIELD, 32'd200);
        yield_at(CMD_YIELD, 32'd201);
        // a ready superuser task shuts the user tasks out of selection
        write_entry(5'd5, 1'b1, ST_READY, 1'b1, 16'd0, 32'd0);
        write_entry(5'd0, 1'b1, ST_RUNNING, 1'b1, 16'd3, 32'd1); // idle entry written
        yield_at(CMD_YIELD, 32'd0);
        yield_at(CMD_STOP, 32'd0);
        // resume of a ready task and of a waiting one
        r = make_req(CMD_RESUME, 5'd5); send_request(r);
        r = make_req(CMD_RESUME, 5'd2); send_request(r);
        r = make_req(CMD_SCHED, 5'd2);  send_request(r);
        r = make_req(CMD_SCHED, 5'd31); send_request(r);
        // unknown commands change nothing
        for (int c = 5; c < 8; c++) begin
            r = make_req(3'(c), 5'd1);
            r.entry_valid = 1'b1; r.entry_status = ST_READY; r.entry_counter = '1;
            send_request(r);
        end
        write_entry(5'd6, 1'b1, ST_RUNNING, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        yield_at(CMD_YIELD, 32'hFFFF_FFFF);
        yield_at(CMD_STOP, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random(int n, int mode);
        t_req r;
        int   pick;
        idle_mode = mode;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            r    = make_req(CMD_WRITE, 5'($urandom));
            if (pick < 32) begin
                r.entry_valid     = $urandom_range(3) != 0;
                r.entry_status    = $urandom_range(2) == 0 ? ST_READY : 2'($urandom);
                r.entry_superuser = $urandom_range(3) == 0;
                r.entry_counter   = $urandom_range(3) == 0 ? 16'hFFFF - 16'($urandom_range(3))
                                                           : 16'($urandom_range(40));
                if ($urandom_range(3) == 0) r.entry_counter = 16'($urandom);
                r.entry_alarm     = $urandom_range(2) == 0 ? 32'd0
                                  : ($urandom_range(1) ? $urandom : $urandom_range(1000));
            end else if (pick < 47) begin
                r.command = CMD_SCHED;
            end else if (pick < 56) begin
                r.command = CMD_RESUME;
            end else if (pick < 82) begin
                r.command = CMD_YIELD;
                if ($urandom_range(1)) r.tick = $urandom_range(1200);
            end else if (pick < 96) begin
                r.command = CMD_STOP;
                if ($urandom_range(1)) r.tick = $urandom_range(1200);
            end else begin
                r.command = 3'($urandom_range(7, 5));
            end
            send_request(r);
        end
        drain();
    endtask

    task automatic test_quantum;
        logic [15:0] q_set [4];
        q_set = '{16'd0, 16'hFFFF, 16'($urandom), QUANTUM_RST};
        foreach (q_set[i]) begin
            set_quantum(q_set[i]);
            test_random(10, IDLE_NONE);
        end
    endtask

    // Stall results for a long stretch while yields keep coming
    task automatic test_backpressure;
        idle_mode = IDLE_NONE;
        hold_req  = 400;
        for (int k = 0; k < 12; k++)
            yield_at($urandom_range(1) ? CMD_YIELD : CMD_STOP, $urandom);
        // pause the sender until everything is back
        req_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge i_clk);
        test_random(8, IDLE_NONE);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        idle_mode      = IDLE_NONE;
        hold_req       = 0;
        err_count      = 0;
        req_count      = 0;
        rsp_count      = 0;
        grant_count    = 0;
        alarm_count    = 0;
        stop_count     = 0;
        quiet_cycles   = 0;
        for (int i = 0; i < TASK_COUNT; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_status[i] = ST_WAITING;
            tbl_super[i]  = 1'b0;
            tbl_count[i]  = '0;
            tbl_alarm[i]  = '0;
        end
        cur_task    = '0;
        quantum_val = QUANTUM_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(50, IDLE_NONE);
        test_random(50, IDLE_SEND);
        test_random(50, IDLE_RECV);
        test_random(50, IDLE_BOTH);
        test_quantum();
        test_backpressure();

        drain();
        $display("Covered %0d requests: %0d grants, %0d alarms, %0d stops reported",
                 req_count, grant_count, alarm_count, stop_count);
        $display("Quantum extremes, four idling patterns and a long result stall run");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### two_class_aging_scheduler.f
rtl/tcas_pkg.sv
rtl/tcas_if.sv
rtl/tcas_ram.sv
rtl/two_class_aging_scheduler.sv
bench/tb.sv
